@@ sv/acrt_pkg.sv @@
// Shared types and constants of the adaptive call-rate throttle.
// Used by acrt_ctrl, acrt_dp and adaptive_call_rate_throttle; depends on nothing.
package acrt_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_DEF  = 48;

  localparam int TARGET_W  = 27;
  localparam int SLEEP_W   = 21;
  localparam int RATE_W    = 31;
  localparam int CALLS_W   = 32;
  localparam int USEC_W    = 20;
  localparam int NUM_W     = CALLS_W + USEC_W;
  localparam int OUT_TDATA_W = 56;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1000);
  localparam logic [USEC_W-1:0]   USEC_PER_SEC = USEC_W'(1000000);
  localparam logic [RATE_W-1:0]   RATE_MAX     = {RATE_W{1'b1}};
  localparam logic [SLEEP_W-1:0]  SLEEP_CAP    = SLEEP_W'(1000000);
  localparam logic [CALLS_W-1:0]  RATE_TOL     = CALLS_W'(10);

  // Reciprocal of ten for values below 2^SLEEP_W: floor(x * DIV10_MUL / 2^DIV10_SHIFT).
  localparam logic [SLEEP_W-1:0] DIV10_MUL   = SLEEP_W'(1677722);
  localparam int                 DIV10_SHIFT = 24;

  // Reciprocals of ten and one hundred for target values below 2^TARGET_W.
  localparam logic [TARGET_W-1:0] T10_MUL    = TARGET_W'(107374183);
  localparam int                  T10_SHIFT  = 30;
  localparam logic [TARGET_W-1:0] T100_MUL   = TARGET_W'(85899346);
  localparam int                  T100_SHIFT = 33;

  typedef enum logic [1:0] {
    DIV_CSLP,
    DIV_CMEAS,
    DIV_RATE
  } div_sel_t;

  typedef enum logic [3:0] {
    S_CFG_A,
    S_CFG_C,
    S_CFG_CW,
    S_CFG_D,
    S_CFG_DW,
    S_IDLE,
    S_CHK,
    S_RATE_W,
    S_ADJ,
    S_MODS,
    S_MODS_W,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     cfg_load;
    logic     div_start;
    div_sel_t div_sel;
    logic     rate_sat;
    logic     adjust;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic meas_hit;
    logic elapsed_zero;
    logic sleep_change;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ sv/adaptive_call_rate_throttle.sv @@
// Top level of the adaptive call-rate throttle.
// Depends on acrt_pkg, acrt_ctrl, acrt_dp and acrt_div.
//
// Each transfer on the in_ channel is one call and carries the current time in
// microseconds. Each call gives one transfer on the out_ channel with the
// pause request, the measurement flag, the last measured rate and the sleep
// interval, unless a target write cuts its work short. cfg_wr_en with cfg_wdata
// sets the target rate in calls per second. An ordinary call passes through the
// check and emit states before out_tvalid rises, and a new call is taken only
// after the last one is done. A call that closes a measurement runs the shared
// restoring divider, DW = max(COUNT_WIDTH, 52) bits wide, once for the rate and
// once more if the sleep interval moves; with no elapsed time the rate run is
// skipped. After reset and after every target write, the measurement and sleep
// intervals are loaded and two divider runs set up the residues; in_tready stays
// low until both runs finish. While the receiver stalls, the finished result waits
// in the output register; one more call is taken and worked on, then in_tready
// stays low until the output register is free.
module adaptive_call_rate_throttle #(
  parameter int COUNT_WIDTH = acrt_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = acrt_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [acrt_pkg::TARGET_W-1:0]     cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((TIME_WIDTH+7)/8)*8-1:0]   in_tdata,   // time_us
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [acrt_pkg::OUT_TDATA_W-1:0]  out_tdata   // pause, measured, measured_rate,
                                                        // sleep_interval_out
);

  acrt_pkg::cmd_t cmd;
  acrt_pkg::sts_t sts;

  acrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  acrt_dp #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wdata  (cfg_wdata),
    .time_us    (in_tdata[TIME_WIDTH-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sv/acrt_div.sv @@
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on nothing; instantiated by acrt_dp.
module acrt_div #(
  parameter int DW = 52,
  parameter int VW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CNT_W = $clog2(DW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    quot_r, quot_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [VW-1:0]    dvs_r, dvs_nxt;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;

  assign trial = {rem_r, quot_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[VW-1:0] : trial[VW-1:0];
      quot_nxt = {quot_r[DW-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

@@ sv/acrt_ctrl.sv @@
// Sequencer of the throttle: setup after reset or a target write, and per-call steps.
// Depends on acrt_pkg; drives acrt_dp through acrt_pkg::cmd_t.
module acrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  acrt_pkg::sts_t sts,
  output acrt_pkg::cmd_t cmd
);

  acrt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acrt_pkg::S_CFG_A;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = acrt_pkg::DIV_CSLP;
    in_tready   = 1'b0;
    unique case (state_r)
      acrt_pkg::S_CFG_A: begin
        cmd.cfg_load = 1'b1;
        state_nxt    = acrt_pkg::S_CFG_C;
      end
      acrt_pkg::S_CFG_C: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = acrt_pkg::DIV_CSLP;
        state_nxt     = acrt_pkg::S_CFG_CW;
      end
      acrt_pkg::S_CFG_CW: begin
        if (sts.div_done) state_nxt = acrt_pkg::S_CFG_D;
      end
      acrt_pkg::S_CFG_D: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = acrt_pkg::DIV_CMEAS;
        state_nxt     = acrt_pkg::S_CFG_DW;
      end
      acrt_pkg::S_CFG_DW: begin
        if (sts.div_done) state_nxt = acrt_pkg::S_IDLE;
      end
      acrt_pkg::S_IDLE: begin
        in_tready = !cfg_wr_en;
        if (in_tvalid && !cfg_wr_en) begin
          cmd.accept = 1'b1;
          state_nxt  = acrt_pkg::S_CHK;
        end
      end
      acrt_pkg::S_CHK: begin
        if (!sts.meas_hit) begin
          state_nxt = acrt_pkg::S_EMIT;
        end else if (sts.elapsed_zero) begin
          cmd.rate_sat = 1'b1;
          state_nxt    = acrt_pkg::S_ADJ;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = acrt_pkg::DIV_RATE;
          state_nxt     = acrt_pkg::S_RATE_W;
        end
      end
      acrt_pkg::S_RATE_W: begin
        if (sts.div_done) state_nxt = acrt_pkg::S_ADJ;
      end
      acrt_pkg::S_ADJ: begin
        cmd.adjust = 1'b1;
        state_nxt  = sts.sleep_change ? acrt_pkg::S_MODS : acrt_pkg::S_EMIT;
      end
      acrt_pkg::S_MODS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = acrt_pkg::DIV_CSLP;
        state_nxt     = acrt_pkg::S_MODS_W;
      end
      acrt_pkg::S_MODS_W: begin
        if (sts.div_done) state_nxt = acrt_pkg::S_EMIT;
      end
      acrt_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = acrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = acrt_pkg::S_IDLE;
      end
    endcase
    if (cfg_wr_en) state_nxt = acrt_pkg::S_CFG_A;
  end

endmodule

@@ sv/acrt_dp.sv @@
// Datapath of the throttle: counters, residues, rate, sleep interval and output register.
// Depends on acrt_pkg and acrt_div; sequenced by acrt_ctrl.
module acrt_dp #(
  parameter int COUNT_WIDTH = acrt_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = acrt_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [acrt_pkg::TARGET_W-1:0]    cfg_wdata,
  input  logic [TIME_WIDTH-1:0]            time_us,
  input  acrt_pkg::cmd_t                   cmd,
  output acrt_pkg::sts_t                   sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [acrt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int DIV_DW = (COUNT_WIDTH > acrt_pkg::NUM_W) ? COUNT_WIDTH : acrt_pkg::NUM_W;
  localparam int DIV_VW = TIME_WIDTH;
  localparam int TW     = acrt_pkg::TARGET_W;
  localparam int SW     = acrt_pkg::SLEEP_W;
  localparam int RW     = acrt_pkg::RATE_W;
  localparam int CW     = acrt_pkg::CALLS_W;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [CW-1:0]          calls_r, calls_nxt;
  logic [TIME_WIDTH-1:0]  wstart_r, wstart_nxt;
  logic [TIME_WIDTH-1:0]  time_r, time_nxt;
  logic [TW-1:0]          target_r, target_nxt;
  logic [TW-1:0]          meas_iv_r, meas_iv_nxt;
  logic [TW-1:0]          mres_r, mres_nxt;
  logic [SW-1:0]          sleep_r, sleep_nxt;
  logic [SW-1:0]          pres_r, pres_nxt;
  logic [SW-1:0]          step_r, step_nxt;
  logic [RW-1:0]          rate_r, rate_nxt;
  logic                   pause_r, pause_nxt;
  logic                   meas_r, meas_nxt;
  acrt_pkg::div_sel_t     sel_r, sel_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [acrt_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [COUNT_WIDTH-1:0] count_inc;
  logic [SW-1:0]          pres_inc, pres_acc;
  logic [TW-1:0]          mres_inc, mres_acc;
  logic [2*SW-1:0]        step_prod;
  logic [SW-1:0]          step_q;
  logic [2*TW-1:0]        t10_prod, t100_prod;
  logic [TW-1:0]          t10_q;
  logic [SW-1:0]          t100_q;
  logic [acrt_pkg::NUM_W-1:0] num;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [CW-1:0]          rate_ext, tgt_ext;
  logic                   too_fast, too_slow;
  logic [SW-1:0]          sleep_adj;
  logic [RW-1:0]          rate_q;
  logic [DIV_DW-1:0]      div_dividend;
  logic [DIV_VW-1:0]      div_divisor;
  logic                   div_busy, div_done;
  logic [DIV_DW-1:0]      div_quot;
  logic [DIV_VW-1:0]      div_rem;
  logic                   out_free;

  assign count_inc = count_r + 1'b1;
  assign pres_inc  = pres_r + 1'b1;
  assign mres_inc  = mres_r + 1'b1;
  assign pres_acc  = (count_inc == '0 || pres_inc == sleep_r) ? '0 : pres_inc;
  assign mres_acc  = (count_inc == '0 || mres_inc == meas_iv_r) ? '0 : mres_inc;

  assign step_prod = sleep_r * acrt_pkg::DIV10_MUL;
  assign step_q    = SW'(step_prod >> acrt_pkg::DIV10_SHIFT);

  assign t10_prod  = target_r * acrt_pkg::T10_MUL;
  assign t10_q     = TW'(t10_prod >> acrt_pkg::T10_SHIFT);
  assign t100_prod = target_r * acrt_pkg::T100_MUL;
  assign t100_q    = SW'(t100_prod >> acrt_pkg::T100_SHIFT);

  assign num     = {{acrt_pkg::USEC_W{1'b0}}, calls_r} *
                   {{CW{1'b0}}, acrt_pkg::USEC_PER_SEC};
  assign elapsed = time_r - wstart_r;

  assign rate_ext = CW'(rate_r);
  assign tgt_ext  = CW'(target_r);
  assign too_fast = rate_ext > (tgt_ext + acrt_pkg::RATE_TOL);
  assign too_slow = (rate_ext + acrt_pkg::RATE_TOL) < tgt_ext;

  always_comb begin
    sleep_adj = sleep_r;
    if (too_fast) begin
      if (sleep_r > SW'(1)) sleep_adj = (sleep_r > step_r) ? sleep_r - step_r : SW'(1);
    end else if (too_slow) begin
      if (sleep_r < acrt_pkg::SLEEP_CAP) sleep_adj = sleep_r + step_r;
    end
  end

  assign rate_q = (|div_quot[DIV_DW-1:RW]) ? acrt_pkg::RATE_MAX : div_quot[RW-1:0];

  always_comb begin
    unique case (cmd.div_sel)
      acrt_pkg::DIV_CSLP: begin
        div_dividend = DIV_DW'(count_r);
        div_divisor  = DIV_VW'(sleep_r);
      end
      acrt_pkg::DIV_CMEAS: begin
        div_dividend = DIV_DW'(count_r);
        div_divisor  = DIV_VW'(meas_iv_r);
      end
      acrt_pkg::DIV_RATE: begin
        div_dividend = DIV_DW'(num);
        div_divisor  = elapsed;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '1;
      end
    endcase
  end

  acrt_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    count_nxt    = count_r;
    calls_nxt    = calls_r;
    wstart_nxt   = wstart_r;
    time_nxt     = time_r;
    target_nxt   = target_r;
    meas_iv_nxt  = meas_iv_r;
    mres_nxt     = mres_r;
    sleep_nxt    = sleep_r;
    pres_nxt     = pres_r;
    step_nxt     = step_r;
    rate_nxt     = rate_r;
    pause_nxt    = pause_r;
    meas_nxt     = meas_r;
    sel_nxt      = sel_r;
    out_data_nxt = out_data_r;

    if (cfg_wr_en) target_nxt = cfg_wdata;
    if (cmd.div_start) sel_nxt = cmd.div_sel;

    if (cmd.cfg_load) begin
      meas_iv_nxt = (t10_q == '0) ? TW'(1) : t10_q;
      sleep_nxt   = (t100_q == '0) ? SW'(1) : t100_q;
    end

    if (cmd.accept) begin
      time_nxt  = time_us;
      count_nxt = count_inc;
      calls_nxt = calls_r + 1'b1;
      pres_nxt  = pres_acc;
      mres_nxt  = mres_acc;
      pause_nxt = (pres_acc == '0);
      meas_nxt  = 1'b0;
      step_nxt  = (step_q == '0) ? SW'(1) : step_q;
    end

    if (cmd.rate_sat) rate_nxt = acrt_pkg::RATE_MAX;

    if (cmd.adjust) begin
      sleep_nxt  = sleep_adj;
      calls_nxt  = '0;
      wstart_nxt = time_r;
      meas_nxt   = 1'b1;
    end

    if (div_done) begin
      case (sel_r)
        acrt_pkg::DIV_CSLP:  pres_nxt = div_rem[SW-1:0];
        acrt_pkg::DIV_CMEAS: mres_nxt = div_rem[TW-1:0];
        acrt_pkg::DIV_RATE:  rate_nxt = rate_q;
        default: ;
      endcase
    end

    if (cmd.load_out) begin
      out_data_nxt = {2'b00, sleep_r, rate_r, meas_r, pause_r};
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      calls_r     <= '0;
      wstart_r    <= '0;
      target_r    <= acrt_pkg::TARGET_RESET;
      meas_iv_r   <= TW'(1);
      mres_r      <= '0;
      sleep_r     <= SW'(1);
      pres_r      <= '0;
      rate_r      <= '0;
      sel_r       <= acrt_pkg::DIV_CSLP;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      calls_r     <= calls_nxt;
      wstart_r    <= wstart_nxt;
      target_r    <= target_nxt;
      meas_iv_r   <= meas_iv_nxt;
      mres_r      <= mres_nxt;
      sleep_r     <= sleep_nxt;
      pres_r      <= pres_nxt;
      rate_r      <= rate_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    time_r     <= time_nxt;
    step_r     <= step_nxt;
    pause_r    <= pause_nxt;
    meas_r     <= meas_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.meas_hit     = (mres_r == '0);
  assign sts.elapsed_zero = (time_r == wstart_r);
  assign sts.sleep_change = (sleep_adj != sleep_r);
  assign sts.div_done     = div_done;
  assign sts.out_free     = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_residues: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (pres_r < sleep_r) && (mres_r < meas_iv_r))
    else $error("Residues out of range when a call is taken.");

  a_sleep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sleep_r != '0)
    else $error("Sleep interval became zero.");

  a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !div_busy)
    else $error("Call taken while the divider is busy.");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("Output register overwritten before its transfer.");

  a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && meas_r) |-> (calls_r == '0))
    else $error("Window count not cleared after a measurement.");

endmodule
